FILE: hdl/snpd_pkg.sv
package snpd_pkg;
  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int NameW = 64;
  localparam int ProtoW = 32;
  localparam int PortW = 16;
  localparam logic [PortW-1:0] PortStart = 16'd2609;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdAlloc = 3'd1;
  localparam logic [2:0] CmdFindName = 3'd2;
  localparam logic [2:0] CmdFindPort = 3'd3;
  localparam logic [2:0] CmdRemove = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNameExists = 3'd1;
  localparam logic [2:0] StTableFull = 3'd2;
  localparam logic [2:0] StUnknownName = 3'd3;
  localparam logic [2:0] StUnknownPort = 3'd4;
  localparam logic [2:0] StUnknownReq = 3'd5;

  // Token that travels down the chain of cells.
  typedef struct packed {
    logic             valid;
    logic [2:0]       command;
    logic [NameW-1:0] name_key;
    logic [ProtoW-1:0] proto_tag;
    logic [PortW-1:0] port_number;
    logic             hit;
    logic             free_seen;
    logic [NameW-1:0] hit_name;
    logic [ProtoW-1:0] hit_proto;
    logic [PortW-1:0] hit_port;
  } snpd_tok_t;
endpackage

FILE: hdl/snpd_cell.sv
module snpd_cell
  import snpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      commit,
  input  logic      commit_add,
  input  snpd_tok_t tok_in,
  output snpd_tok_t tok_out
);
  logic              used;
  logic [NameW-1:0]  name;
  logic [ProtoW-1:0] proto;
  logic [PortW-1:0]  port;
  logic name_match, port_match, claim;
  snpd_tok_t tok_next;

  // Match against this cell's entry; an earlier hit takes precedence.
  always_comb begin
    name_match = used && (name == tok_in.name_key);
    port_match = used && (port == tok_in.port_number);
    claim = tok_in.valid && !used && !tok_in.free_seen &&
            (tok_in.command == CmdAdd || tok_in.command == CmdAlloc);
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.hit) begin
      if ((tok_in.command == CmdFindPort) ? port_match : name_match) begin
        tok_next.hit = 1'b1;
        tok_next.hit_name = name;
        tok_next.hit_proto = proto;
        tok_next.hit_port = port;
      end
    end
    if (claim) tok_next.free_seen = 1'b1;
  end

  // Pending write or remove, applied once the final verdict is known.
  logic pend_add, pend_rm;
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      pend_add <= 1'b0;
      pend_rm <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.valid) begin
        pend_add <= claim;
        pend_rm <= tok_in.command == CmdRemove && !tok_in.hit && name_match;
      end
      if (commit) begin
        if (pend_add && commit_add) begin
          used <= 1'b1;
        end
        if (pend_rm) used <= 1'b0;
        pend_add <= 1'b0;
        pend_rm <= 1'b0;
      end
    end
    if (tok_in.valid && claim) begin
      name <= tok_in.name_key;
      proto <= tok_in.proto_tag;
      port <= tok_in.port_number;
    end
  end
endmodule

FILE: hdl/service_name_port_directory.sv
// Each request passes through the registered cells of the chain, then the result register.
// Throughput: one request at a time; the token walks the chain of cells one cell per cycle.
// The next request is accepted once the result has been taken.
// Reset (synchronous rst): all slots free, port counter at 2609, no result pending.
module service_name_port_directory
  import snpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        command,
  input  logic [NameW-1:0]  name_key,
  input  logic [ProtoW-1:0] proto_tag,
  input  logic [PortW-1:0]  port_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [NameW-1:0]  found_name,
  output logic [ProtoW-1:0] found_proto,
  output logic [PortW-1:0]  found_port
);
  snpd_tok_t chain [Entries+1];
  snpd_tok_t head;
  logic busy, commit, commit_add;
  logic [PortW-1:0] next_port;
  snpd_tok_t last;

  assign in_ready = !busy;

  // Inject the request; allocate substitutes the counter value as port.
  always_comb begin
    head = '0;
    head.valid = in_valid && in_ready;
    head.command = command;
    head.name_key = name_key;
    head.proto_tag = proto_tag;
    head.port_number = (command == CmdAlloc) ? next_port : port_number;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    snpd_cell u_cell (
      .clk(clk), .rst(rst), .commit(commit), .commit_add(commit_add),
      .tok_in(chain[i]), .tok_out(chain[i+1])
    );
  end

  assign last = chain[Entries];

  logic add_ok;
  logic [2:0]        status_next;
  logic [NameW-1:0]  found_name_next;
  logic [ProtoW-1:0] found_proto_next;
  logic [PortW-1:0]  found_port_next;

  // Final verdict of the request leaving the chain.
  always_comb begin
    add_ok = !last.hit && last.free_seen;
    commit = last.valid;
    commit_add = last.valid && add_ok;
    status_next = StOk;
    found_name_next = '0;
    found_proto_next = '0;
    found_port_next = '0;
    unique case (last.command)
      CmdAdd, CmdAlloc: begin
        if (last.hit) status_next = StNameExists;
        else if (!add_ok) status_next = StTableFull;
        else if (last.command == CmdAlloc) found_port_next = last.port_number;
      end
      CmdFindName: begin
        if (!last.hit) status_next = StUnknownName;
        else begin
          found_proto_next = last.hit_proto;
          found_port_next = last.hit_port;
        end
      end
      CmdFindPort: begin
        if (!last.hit) status_next = StUnknownPort;
        else begin
          found_name_next = last.hit_name;
          found_proto_next = last.hit_proto;
        end
      end
      CmdRemove: if (!last.hit) status_next = StUnknownName;
      default: status_next = StUnknownReq;
    endcase
  end

  // Result register and request control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      next_port <= PortStart;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        if (command == CmdAlloc) next_port <= next_port + 1'b1;
      end
      if (last.valid) out_valid <= 1'b1;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
        busy <= 1'b0;
      end
    end
    if (last.valid) begin
      status <= status_next;
      found_name <= found_name_next;
      found_proto <= found_proto_next;
      found_port <= found_port_next;
    end
  end

  // Cells commit their pending add only if the request actually succeeds.
endmodule
